@@ rtl/rv32ie_pkg.sv @@
// Shared types, operation codes and decode helpers for the RV32I execute unit.
package rv32ie_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [5:0] {
    OP_ADD    = 6'd0,
    OP_SUB    = 6'd1,
    OP_SLL    = 6'd2,
    OP_SLT    = 6'd3,
    OP_SLTU   = 6'd4,
    OP_XOR    = 6'd5,
    OP_SRL    = 6'd6,
    OP_SRA    = 6'd7,
    OP_OR     = 6'd8,
    OP_AND    = 6'd9,
    OP_ADDI   = 6'd10,
    OP_SLTI   = 6'd11,
    OP_SLTIU  = 6'd12,
    OP_XORI   = 6'd13,
    OP_ORI    = 6'd14,
    OP_ANDI   = 6'd15,
    OP_SLLI   = 6'd16,
    OP_SRLI   = 6'd17,
    OP_SRAI   = 6'd18,
    OP_LB     = 6'd19,
    OP_LH     = 6'd20,
    OP_LW     = 6'd21,
    OP_LBU    = 6'd22,
    OP_LHU    = 6'd23,
    OP_SB     = 6'd24,
    OP_SH     = 6'd25,
    OP_SW     = 6'd26,
    OP_BEQ    = 6'd27,
    OP_BNE    = 6'd28,
    OP_BLT    = 6'd29,
    OP_BGE    = 6'd30,
    OP_BLTU   = 6'd31,
    OP_BGEU   = 6'd32,
    OP_JAL    = 6'd33,
    OP_JALR   = 6'd34,
    OP_LUI    = 6'd35,
    OP_AUIPC  = 6'd36,
    OP_ECALL  = 6'd37,
    OP_EBREAK = 6'd38,
    OP_FENCE  = 6'd39
  } op_e;

  typedef enum logic [3:0] {
    ALU_ADD  = 4'd0,
    ALU_SUB  = 4'd1,
    ALU_SLL  = 4'd2,
    ALU_SLT  = 4'd3,
    ALU_SLTU = 4'd4,
    ALU_XOR  = 4'd5,
    ALU_SRL  = 4'd6,
    ALU_SRA  = 4'd7,
    ALU_OR   = 4'd8,
    ALU_AND  = 4'd9
  } alu_fn_e;

  // Executed instruction on its way to the load alignment and writeback stage.
  typedef struct packed {
    logic        wr;
    logic [4:0]  rd;
    word_t       val;
    word_t       npc;
    logic        taken;
    logic        halted;
    logic        is_load;
    op_e         op;
    logic [1:0]  boff;
  } exec_t;

  function automatic alu_fn_e alu_fn_of(input op_e op);
    alu_fn_e fn;
    fn = ALU_ADD;
    unique case (op)
      OP_SUB:            fn = ALU_SUB;
      OP_SLL, OP_SLLI:   fn = ALU_SLL;
      OP_SLT, OP_SLTI:   fn = ALU_SLT;
      OP_SLTU, OP_SLTIU: fn = ALU_SLTU;
      OP_XOR, OP_XORI:   fn = ALU_XOR;
      OP_SRL, OP_SRLI:   fn = ALU_SRL;
      OP_SRA, OP_SRAI:   fn = ALU_SRA;
      OP_OR, OP_ORI:     fn = ALU_OR;
      OP_AND, OP_ANDI:   fn = ALU_AND;
      default:           fn = ALU_ADD;
    endcase
    return fn;
  endfunction

endpackage

@@ rtl/rv32ie_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rv32ie_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rv32ie_alu.sv @@
// Integer ALU and branch comparator for the RV32I execute unit.
module rv32ie_alu (
  input  rv32ie_pkg::op_e   op_i,
  input  rv32ie_pkg::word_t a_i,
  input  rv32ie_pkg::word_t b_i,
  input  rv32ie_pkg::word_t imm_i,
  output rv32ie_pkg::word_t res_o,
  output logic              br_take_o
);
  import rv32ie_pkg::*;

  alu_fn_e    fn;
  word_t      opnd_b;
  logic [4:0] sh;

  always_comb begin
    fn     = alu_fn_of(op_i);
    opnd_b = (op_i <= OP_AND) ? b_i : imm_i;
    sh     = opnd_b[4:0];
    case (fn)
      ALU_ADD:  res_o = a_i + opnd_b;
      ALU_SUB:  res_o = a_i - opnd_b;
      ALU_SLL:  res_o = a_i << sh;
      ALU_SLT:  res_o = {31'b0, $signed(a_i) < $signed(opnd_b)};
      ALU_SLTU: res_o = {31'b0, a_i < opnd_b};
      ALU_XOR:  res_o = a_i ^ opnd_b;
      ALU_SRL:  res_o = a_i >> sh;
      ALU_SRA:  res_o = word_t'($signed(a_i) >>> sh);
      ALU_OR:   res_o = a_i | opnd_b;
      ALU_AND:  res_o = a_i & opnd_b;
      default:  res_o = a_i & opnd_b;
    endcase
  end

  always_comb begin
    unique case (op_i)
      OP_BEQ:  br_take_o = (a_i == b_i);
      OP_BNE:  br_take_o = (a_i != b_i);
      OP_BLT:  br_take_o = ($signed(a_i) < $signed(b_i));
      OP_BGE:  br_take_o = !($signed(a_i) < $signed(b_i));
      OP_BLTU: br_take_o = (a_i < b_i);
      OP_BGEU: br_take_o = (a_i >= b_i);
      default: br_take_o = 1'b0;
    endcase
  end

endmodule

@@ rtl/rv32i_execute_unit.sv @@
// Top level of the RV32I execute unit: pipeline, register file, data memory and stream ports.
//
// One decoded instruction is taken per beat and one result beat is returned for it, in order.
// The unit sustains one instruction per cycle while the output is not stalled; each
// instruction passes through the execute stage, the load alignment and writeback stage and
// the output register in turn. The register file and the data memory are RAMs with registered
// reads, and results still in flight are forwarded to the execute stage, so dependent
// instructions follow each other without a gap. The data memory is four byte-wide banks so
// that any aligned or misaligned access, including one that wraps past the top, completes in
// a single pass. DMEM_BYTES must be a power of two. After reset the data memory is cleared one
// row of four bytes per cycle, and s_axis_tready stays low until that sweep has finished.
module rv32i_execute_unit #(
  parameter int DMEM_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op [5:0], dest_reg [10:6], src_reg_a [15:11], src_reg_b [20:16], immediate [52:21], zeros
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc [31:0], reg_written [32], written_reg [37:33], written_value [69:38],
  // branch_taken [70], halted [71]
  output logic [71:0] m_axis_tdata
);
  import rv32ie_pkg::*;

  localparam int AddrW = $clog2(DMEM_BYTES);
  localparam int RowW  = AddrW - 2;
  localparam int Rows  = DMEM_BYTES / 4;

  // Input beat fields.
  op_e        in_op;
  logic [4:0] in_rd;
  logic [4:0] in_rs1;
  logic [4:0] in_rs2;
  word_t      in_imm;
  logic       accept;
  logic       adv;

  // Architectural and control state.
  word_t      pc_q;
  logic       halt_q;
  logic [31:0] rf_vld_q;
  logic       clr_busy_q;
  logic [RowW-1:0] clr_row_q;

  // Execute stage.
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [4:0] s1_rd_q;
  logic [4:0] s1_rs1_q;
  logic [4:0] s1_rs2_q;
  word_t      s1_imm_q;
  logic       s1_vld_a_q;
  logic       s1_vld_b_q;
  word_t      rf_a_rdata;
  word_t      rf_b_rdata;
  word_t      op_a;
  word_t      op_b;
  word_t      alu_res;
  logic       br_take;
  word_t      pc4;
  word_t      sum_ai;
  word_t      upper;
  exec_t      ex;
  logic       is_store;
  logic       st_en;
  logic       ld_en;
  logic [AddrW-1:0] maddr;

  // Last register write, which the register RAM cannot yet return.
  logic       fw_valid_q;
  logic [4:0] fw_reg_q;
  word_t      fw_val_q;

  // Load alignment and writeback stage.
  logic       s2_valid_q;
  exec_t      s2_q;
  logic       s2_wr;
  word_t      s2_val;
  word_t      ld_word;

  // Data memory banks.
  logic [3:0]      bank_we;
  logic [RowW-1:0] bank_waddr [4];
  logic [7:0]      bank_wdata [4];
  logic [RowW-1:0] bank_raddr [4];
  logic [7:0]      bank_rdata [4];

  // Output register.
  logic       out_valid_q;
  word_t      out_npc_q;
  logic       out_wr_q;
  logic [4:0] out_rd_q;
  word_t      out_val_q;
  logic       out_taken_q;
  logic       out_halted_q;

  assign in_op  = op_e'(s_axis_tdata[5:0]);
  assign in_rd  = s_axis_tdata[10:6];
  assign in_rs1 = s_axis_tdata[15:11];
  assign in_rs2 = s_axis_tdata[20:16];
  assign in_imm = s_axis_tdata[52:21];

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !clr_busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Register file: two copies give two read ports; both take every write.
  rv32ie_ram #(.Width(32), .Depth(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (adv && s2_wr),
    .waddr_i (s2_q.rd),
    .wdata_i (s2_val),
    .re_i    (accept),
    .raddr_i (in_rs1),
    .rdata_o (rf_a_rdata)
  );

  rv32ie_ram #(.Width(32), .Depth(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (adv && s2_wr),
    .waddr_i (s2_q.rd),
    .wdata_i (s2_val),
    .re_i    (accept),
    .raddr_i (in_rs2),
    .rdata_o (rf_b_rdata)
  );

  // Operand forwarding: the instruction one ahead, then the write made as the operands were read.
  always_comb begin
    if (s2_wr && s2_q.rd == s1_rs1_q) begin
      op_a = s2_val;
    end else if (fw_valid_q && fw_reg_q == s1_rs1_q) begin
      op_a = fw_val_q;
    end else begin
      op_a = s1_vld_a_q ? rf_a_rdata : '0;
    end
    if (s2_wr && s2_q.rd == s1_rs2_q) begin
      op_b = s2_val;
    end else if (fw_valid_q && fw_reg_q == s1_rs2_q) begin
      op_b = fw_val_q;
    end else begin
      op_b = s1_vld_b_q ? rf_b_rdata : '0;
    end
  end

  rv32ie_alu u_alu (
    .op_i      (s1_op_q),
    .a_i       (op_a),
    .b_i       (op_b),
    .imm_i     (s1_imm_q),
    .res_o     (alu_res),
    .br_take_o (br_take)
  );

  assign pc4    = pc_q + 32'd4;
  assign sum_ai = op_a + s1_imm_q;
  assign upper  = s1_imm_q << 12;
  assign maddr  = sum_ai[AddrW-1:0];

  always_comb begin
    ex         = '0;
    ex.rd      = s1_rd_q;
    ex.op      = s1_op_q;
    ex.boff    = maddr[1:0];
    ex.npc     = pc4;
    ex.halted  = halt_q;
    is_store   = 1'b0;
    if (halt_q) begin
      ex.npc = pc_q;
    end else begin
      unique case (s1_op_q) inside
        [OP_ADD:OP_SRAI]: begin
          ex.wr  = 1'b1;
          ex.val = alu_res;
        end
        [OP_LB:OP_LHU]: begin
          ex.wr      = 1'b1;
          ex.is_load = 1'b1;
        end
        [OP_SB:OP_SW]: begin
          is_store = 1'b1;
        end
        [OP_BEQ:OP_BGEU]: begin
          if (br_take) begin
            ex.taken = 1'b1;
            ex.npc   = pc_q + s1_imm_q;
          end
        end
        OP_JAL: begin
          ex.wr    = 1'b1;
          ex.val   = pc4;
          ex.taken = 1'b1;
          ex.npc   = pc_q + s1_imm_q;
        end
        OP_JALR: begin
          ex.wr    = 1'b1;
          ex.val   = pc4;
          ex.taken = 1'b1;
          ex.npc   = {sum_ai[31:1], 1'b0};
        end
        OP_LUI: begin
          ex.wr  = 1'b1;
          ex.val = upper;
        end
        OP_AUIPC: begin
          ex.wr  = 1'b1;
          ex.val = pc_q + upper;
        end
        OP_ECALL, OP_EBREAK: begin
          ex.halted = 1'b1;
          ex.npc    = pc_q;
        end
        default: begin
        end
      endcase
    end
    if (ex.rd == 5'd0) begin
      ex.wr = 1'b0;
    end
  end

  assign st_en = s1_valid_q && adv && is_store;
  assign ld_en = s1_valid_q && adv && ex.is_load;

  // Byte k of an access lives in bank (address + k) mod 4.
  always_comb begin
    logic [1:0]       k;
    logic [AddrW-1:0] baddr;
    logic             in_size;
    for (int j = 0; j < 4; j++) begin
      k       = 2'(j) - maddr[1:0];
      baddr   = maddr + AddrW'(k);
      in_size = (k == 2'd0) || (k == 2'd1 && s1_op_q != OP_SB) || (s1_op_q == OP_SW);
      bank_raddr[j] = baddr[AddrW-1:2];
      if (clr_busy_q) begin
        bank_we[j]    = 1'b1;
        bank_waddr[j] = clr_row_q;
        bank_wdata[j] = 8'h00;
      end else begin
        bank_we[j]    = st_en && in_size;
        bank_waddr[j] = baddr[AddrW-1:2];
        bank_wdata[j] = op_b[8*k +: 8];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rv32ie_ram #(.Width(8), .Depth(Rows)) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr[g]),
      .wdata_i (bank_wdata[g]),
      .re_i    (ld_en),
      .raddr_i (bank_raddr[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_word[8*k +: 8] = bank_rdata[2'(s2_q.boff + 2'(k))];
    end
  end

  always_comb begin
    s2_val = s2_q.val;
    if (s2_q.is_load) begin
      case (s2_q.op)
        OP_LB:   s2_val = {{24{ld_word[7]}}, ld_word[7:0]};
        OP_LH:   s2_val = {{16{ld_word[15]}}, ld_word[15:0]};
        OP_LBU:  s2_val = {24'b0, ld_word[7:0]};
        OP_LHU:  s2_val = {16'b0, ld_word[15:0]};
        default: s2_val = ld_word;
      endcase
    end
  end

  assign s2_wr = s2_valid_q && s2_q.wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      halt_q      <= 1'b0;
      rf_vld_q    <= '0;
      clr_busy_q  <= 1'b1;
      clr_row_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fw_valid_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == RowW'(Rows - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_q  <= accept;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
        fw_valid_q  <= s2_wr;
        if (s2_wr) begin
          rf_vld_q[s2_q.rd] <= 1'b1;
        end
        if (s1_valid_q) begin
          pc_q   <= ex.npc;
          halt_q <= ex.halted;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_op;
      s1_rd_q    <= in_rd;
      s1_rs1_q   <= in_rs1;
      s1_rs2_q   <= in_rs2;
      s1_imm_q   <= in_imm;
      s1_vld_a_q <= rf_vld_q[in_rs1];
      s1_vld_b_q <= rf_vld_q[in_rs2];
    end
    if (adv) begin
      s2_q         <= ex;
      fw_reg_q     <= s2_q.rd;
      fw_val_q     <= s2_val;
      out_npc_q    <= s2_q.npc;
      out_wr_q     <= s2_q.wr;
      out_rd_q     <= s2_q.wr ? s2_q.rd : 5'd0;
      out_val_q    <= s2_q.wr ? s2_val : '0;
      out_taken_q  <= s2_q.taken;
      out_halted_q <= s2_q.halted;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_halted_q, out_taken_q, out_val_q, out_rd_q, out_wr_q, out_npc_q};

endmodule

@@ tb/rv32i_execute_unit_tb.sv @@
// Self-checking testbench for the RV32I execute unit: stream driver, stall pattern and checker.
`timescale 1ns / 1ps

module rv32i_execute_unit_tb;
  import rv32ie_pkg::*;

  localparam int unsigned DMEM_BYTES = 4096;
  localparam int ITEM_TARGET = 1550;
  localparam int WATCHDOG_LIMIT = 8192;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_EVERY = 400;
  localparam logic [5:0] OP_FIRST_UNUSED = 6'd40;
  localparam logic [5:0] OP_LAST_UNUSED = 6'd63;

  typedef struct packed {
    logic [5:0] op;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    word_t      imm;
    logic       hold;
  } instr_t;

  typedef struct packed {
    word_t      next_pc;
    logic       reg_written;
    logic [4:0] written_reg;
    word_t      written_value;
    logic       branch_taken;
    logic       halted;
  } retire_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  instr_t  pending_instrs[$];
  retire_t expected_results[$];

  word_t      arch_pc;
  word_t      arch_gpr[32];
  logic [7:0] arch_dmem[DMEM_BYTES];
  logic       arch_halted;

  int   n_queued = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  logic send_now;
  int   ready_mode = 0;
  int   ready_phase = 0;
  int   ready_tick = 0;
  int   out_beats = 0;
  int   err_count = 0;
  int   idle_cycles = 0;

  rv32i_execute_unit #(
    .DMEM_BYTES(DMEM_BYTES)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic retire_t execute_instr(input instr_t it);
    retire_t r;
    word_t a, b, opnd, ad, raw, val, npc;
    logic wr, taken, cond;
    int nbytes;
    a = arch_gpr[it.rs1];
    b = arch_gpr[it.rs2];
    opnd = (it.op <= OP_AND) ? b : it.imm;
    ad = a + it.imm;
    npc = arch_pc + 32'd4;
    wr = 1'b0;
    taken = 1'b0;
    cond = 1'b0;
    val = '0;
    raw = '0;
    nbytes = (it.op == OP_LB || it.op == OP_LBU || it.op == OP_SB) ? 1 :
             (it.op == OP_LW || it.op == OP_SW) ? 4 : 2;
    if (arch_halted) begin
      npc = arch_pc;
    end else begin
      case (it.op)
        OP_ADD, OP_ADDI: val = a + opnd;
        OP_SUB: val = a - b;
        OP_SLL, OP_SLLI: val = a << opnd[4:0];
        OP_SLT, OP_SLTI: val = {31'b0, $signed(a) < $signed(opnd)};
        OP_SLTU, OP_SLTIU: val = {31'b0, a < opnd};
        OP_XOR, OP_XORI: val = a ^ opnd;
        OP_SRL, OP_SRLI: val = a >> opnd[4:0];
        OP_SRA, OP_SRAI: val = word_t'($signed(a) >>> opnd[4:0]);
        OP_OR, OP_ORI: val = a | opnd;
        OP_AND, OP_ANDI: val = a & opnd;
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          for (int k = 0; k < nbytes; k++) raw[8*k +: 8] = arch_dmem[(ad + k) % DMEM_BYTES];
          case (it.op)
            OP_LB: val = {{24{raw[7]}}, raw[7:0]};
            OP_LH: val = {{16{raw[15]}}, raw[15:0]};
            default: val = raw;
          endcase
        end
        OP_SB, OP_SH, OP_SW: begin
          for (int k = 0; k < nbytes; k++) arch_dmem[(ad + k) % DMEM_BYTES] = b[8*k +: 8];
        end
        OP_BEQ: cond = (a == b);
        OP_BNE: cond = (a != b);
        OP_BLT: cond = $signed(a) < $signed(b);
        OP_BGE: cond = $signed(a) >= $signed(b);
        OP_BLTU: cond = a < b;
        OP_BGEU: cond = a >= b;
        OP_JAL: begin
          val = arch_pc + 32'd4;
          npc = arch_pc + it.imm;
        end
        OP_JALR: begin
          val = arch_pc + 32'd4;
          npc = ad & 32'hFFFF_FFFE;
        end
        OP_LUI: val = it.imm << 12;
        OP_AUIPC: val = arch_pc + (it.imm << 12);
        OP_ECALL, OP_EBREAK: begin
          arch_halted = 1'b1;
          npc = arch_pc;
        end
        default: ;
      endcase
      wr = (it.op <= OP_LHU) || (it.op >= OP_JAL && it.op <= OP_AUIPC);
      taken = cond || it.op == OP_JAL || it.op == OP_JALR;
      if (cond) npc = arch_pc + it.imm;
    end
    if (wr && it.rd != 5'd0) arch_gpr[it.rd] = val;
    else wr = 1'b0;
    arch_pc = npc;
    r.next_pc = npc;
    r.reg_written = wr;
    r.written_reg = wr ? it.rd : 5'd0;
    r.written_value = wr ? val : '0;
    r.branch_taken = taken;
    r.halted = arch_halted;
    return r;
  endfunction

  function automatic void push_instr(input logic [5:0] op, input logic [4:0] rd,
                                     input logic [4:0] rs1, input logic [4:0] rs2,
                                     input word_t imm, input logic hold_req);
    instr_t it;
    n_queued++;
    it.op = op;
    it.rd = rd;
    it.rs1 = rs1;
    it.rs2 = rs2;
    it.imm = imm;
    it.hold = hold_req || (n_queued % HOLD_EVERY == 0);
    pending_instrs.insert(pending_instrs.size(), it);
  endfunction

  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic word_t rand_imm();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4, 5: return $urandom;
      default: return word_t'($urandom_range(0, 4095)) - 32'd2048;
    endcase
  endfunction

  function automatic word_t mem_offset();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom_range(DMEM_BYTES - 8, DMEM_BYTES - 1));
      1: return word_t'($urandom_range(0, 31)) | ($urandom & ~word_t'(DMEM_BYTES - 1));
      default: return word_t'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(),
                                execute_instr(pending_instrs.pop_front()));
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      send_now = burst_left > 0 && pending_instrs.size() > 0 &&
                 !(pending_instrs[0].hold && expected_results.size() > 0);
      s_axis_tvalid <= send_now;
      if (send_now) begin
        s_axis_tdata <= {3'b000, pending_instrs[0].imm, pending_instrs[0].rs2,
                         pending_instrs[0].rs1, pending_instrs[0].rd, pending_instrs[0].op};
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_phase == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_phase = $urandom_range(32, 200);
      end else begin
        ready_phase--;
      end
      ready_tick++;
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (ready_tick % 7) < 4;
      endcase
    end
  end

  always @(posedge clk_i) begin
    retire_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.next_pc = m_axis_tdata[31:0];
      got.reg_written = m_axis_tdata[32];
      got.written_reg = m_axis_tdata[37:33];
      got.written_value = m_axis_tdata[69:38];
      got.branch_taken = m_axis_tdata[70];
      got.halted = m_axis_tdata[71];
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result beat %0d arrived with nothing outstanding: %h",
                             out_beats, m_axis_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.next_pc !== want.next_pc)
          flag_error($sformatf("beat %0d next_pc: expected %h, got %h",
                               out_beats, want.next_pc, got.next_pc));
        if (got.reg_written !== want.reg_written)
          flag_error($sformatf("beat %0d reg_written: expected %b, got %b",
                               out_beats, want.reg_written, got.reg_written));
        if (got.written_reg !== want.written_reg)
          flag_error($sformatf("beat %0d written_reg: expected %0d, got %0d",
                               out_beats, want.written_reg, got.written_reg));
        if (got.written_value !== want.written_value)
          flag_error($sformatf("beat %0d written_value: expected %h, got %h",
                               out_beats, want.written_value, got.written_value));
        if (got.branch_taken !== want.branch_taken)
          flag_error($sformatf("beat %0d branch_taken: expected %b, got %b",
                               out_beats, want.branch_taken, got.branch_taken));
        if (got.halted !== want.halted)
          flag_error($sformatf("beat %0d halted: expected %b, got %b",
                               out_beats, want.halted, got.halted));
      end
      out_beats++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_instrs.size() == 0 && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [5:0] op;
    logic [4:0] rd, rs1;
    word_t imm;
    int pick;

    arch_pc = '0;
    arch_halted = 1'b0;
    foreach (arch_gpr[i]) arch_gpr[i] = '0;
    foreach (arch_dmem[i]) arch_dmem[i] = '0;

    push_instr(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFFF, 1'b0);
    push_instr(OP_LUI, 5'd2, 5'd0, 5'd0, 32'h0008_0000, 1'b0);
    push_instr(OP_ADDI, 5'd3, 5'd2, 5'd0, 32'hFFFF_FFFF, 1'b0);
    push_instr(OP_SRA, 5'd4, 5'd2, 5'd1, '0, 1'b0);
    push_instr(OP_SRL, 5'd5, 5'd2, 5'd1, '0, 1'b0);
    push_instr(OP_SLLI, 5'd6, 5'd1, 5'd0, 32'hFFFF_FFE1, 1'b0);
    push_instr(OP_SRAI, 5'd7, 5'd3, 5'd0, 32'h0000_0020, 1'b0);
    push_instr(OP_SLT, 5'd8, 5'd2, 5'd3, '0, 1'b0);
    push_instr(OP_SLTU, 5'd9, 5'd2, 5'd3, '0, 1'b0);
    push_instr(OP_ADD, 5'd0, 5'd1, 5'd1, '0, 1'b0);
    push_instr(OP_SW, 5'd0, 5'd0, 5'd3, word_t'(DMEM_BYTES - 2), 1'b0);
    push_instr(OP_LW, 5'd10, 5'd0, 5'd0, 32'hFFFF_FFFE, 1'b0);
    push_instr(OP_SH, 5'd0, 5'd1, 5'd2, 32'h0000_0002, 1'b0);
    push_instr(OP_LB, 5'd11, 5'd0, 5'd0, '0, 1'b0);
    push_instr(OP_LHU, 5'd12, 5'd0, 5'd0, 32'h0000_0001, 1'b0);
    push_instr(OP_LH, 5'd13, 5'd1, 5'd0, word_t'(DMEM_BYTES), 1'b0);
    push_instr(OP_LBU, 5'd14, 5'd0, 5'd0, 32'h8000_0FFF, 1'b0);
    push_instr(OP_SB, 5'd0, 5'd0, 5'd5, '0, 1'b0);
    push_instr(OP_BGEU, 5'd0, 5'd2, 5'd3, 32'hFFFF_FFF8, 1'b0);
    push_instr(OP_BLT, 5'd0, 5'd2, 5'd3, 32'h7FFF_FFFC, 1'b0);
    push_instr(OP_BGE, 5'd0, 5'd2, 5'd3, 32'h0000_0010, 1'b0);
    push_instr(OP_BNE, 5'd0, 5'd1, 5'd1, 32'h0000_0010, 1'b0);
    push_instr(OP_JAL, 5'd15, 5'd0, 5'd0, 32'h8000_0000, 1'b0);
    push_instr(OP_JALR, 5'd16, 5'd1, 5'd0, '0, 1'b0);
    push_instr(OP_JALR, 5'd17, 5'd17, 5'd0, 32'h0000_0003, 1'b0);
    push_instr(OP_AUIPC, 5'd18, 5'd0, 5'd0, 32'h000F_FFFF, 1'b0);
    push_instr(OP_FENCE, 5'd19, 5'd1, 5'd2, 32'hFFFF_FFFF, 1'b0);
    push_instr(OP_LAST_UNUSED, 5'd31, 5'd31, 5'd31, 32'h5A5A_A5A5, 1'b0);
    push_instr(OP_BEQ, 5'd0, 5'd0, 5'd0, '0, 1'b1);

    while (n_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        do op = 6'($urandom_range(OP_ADD, OP_FENCE));
        while (op == OP_ECALL || op == OP_EBREAK);
        rs1 = rand_reg();
        imm = rand_imm();
        if (op >= OP_LB && op <= OP_SW && $urandom_range(0, 1) == 1) begin
          rs1 = 5'd0;
          imm = mem_offset();
        end else if (op >= OP_BEQ && op <= OP_JAL && $urandom_range(0, 3) != 0) begin
          imm = word_t'($urandom_range(0, 255) * 4) - 32'd512;
        end
        push_instr(op, rand_reg(), rs1, rand_reg(), imm, 1'b0);
      end else if (pick < 80) begin
        imm = mem_offset();
        push_instr(6'($urandom_range(OP_SB, OP_SW)), rand_reg(), 5'd0, rand_reg(), imm, 1'b0);
        repeat ($urandom_range(1, 3)) begin
          push_instr(6'($urandom_range(OP_LB, OP_LHU)), rand_reg(), 5'd0, rand_reg(),
                     imm + word_t'($urandom_range(0, 3)), 1'b0);
        end
      end else if (pick < 92) begin
        rd = 5'($urandom_range(1, 31));
        push_instr(OP_LUI, rd, rand_reg(), rand_reg(), $urandom, 1'b0);
        push_instr(OP_ADDI, rd, rd, rand_reg(), rand_imm(), 1'b0);
        push_instr(6'($urandom_range(OP_ADD, OP_AND)), rand_reg(), rd, rand_reg(), rand_imm(),
                   1'b0);
      end else begin
        push_instr(6'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), rand_reg(), rand_reg(),
                   rand_reg(), $urandom, 1'b0);
      end
    end

    // The halt is sticky, so the instructions queued after it check that the unit stays halted.
    push_instr(($urandom_range(0, 1) == 1) ? OP_ECALL : OP_EBREAK, rand_reg(), rand_reg(),
               rand_reg(), $urandom, 1'b1);
    push_instr(OP_ECALL, rand_reg(), rand_reg(), rand_reg(), $urandom, 1'b0);
    push_instr(OP_EBREAK, rand_reg(), rand_reg(), rand_reg(), $urandom, 1'b0);
    push_instr(OP_JAL, 5'd1, 5'd0, 5'd0, 32'h0000_0040, 1'b0);
    push_instr(OP_SW, 5'd0, 5'd0, 5'd1, '0, 1'b0);
    repeat (6) push_instr(6'($urandom), rand_reg(), rand_reg(), rand_reg(), $urandom, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_instrs.size() == 0 && expected_results.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (err_count == 0 && expected_results.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
